// ----- src/i2cea_pkg.sv -----
package i2cea_pkg;

  // field widths
  localparam int KIND_W    = 2;
  localparam int ADDR_W    = 16;
  localparam int COUNT_W   = 16;
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int ACTION_W  = 3;
  localparam int ERR_W     = 2;
  localparam int DEV_W     = 7;
  localparam int POLL_W    = 24;
  localparam int CFG_IDX_W = 1;

  // parameter defaults
  localparam int PAGE_BYTES_DEF = 64;
  localparam int ADDR_BITS_DEF  = 16;

  // register reset values
  localparam logic [DEV_W-1:0]  DEVICE_ADDRESS_RST = 7'd80;
  localparam logic [POLL_W-1:0] POLL_LIMIT_RST     = 24'd10000000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT     = 1'b1;

  // input item kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RESP  = 2'd3;

  // bus response status
  localparam logic [STATUS_W-1:0] ST_ACK  = 2'd0;

  // bus actions
  localparam logic [ACTION_W-1:0] ACT_NONE    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_START   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_RESTART = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_SEND    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_RX_ACK  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_RX_NACK = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_STOP    = 3'd6;

  // error codes
  localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_WRITE   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_READ    = 2'd2;
  localparam logic [ERR_W-1:0] ERR_TIMEOUT = 2'd3;

  // sequencer phases
  typedef enum logic [11:0] {
    PH_IDLE      = 12'b0000_0000_0001,
    PH_START     = 12'b0000_0000_0010,
    PH_DEVW      = 12'b0000_0000_0100,
    PH_POLL_RS   = 12'b0000_0000_1000,
    PH_ADDRH     = 12'b0000_0001_0000,
    PH_ADDRL     = 12'b0000_0010_0000,
    PH_WAIT_DATA = 12'b0000_0100_0000,
    PH_WR_DATA   = 12'b0000_1000_0000,
    PH_RD_RS     = 12'b0001_0000_0000,
    PH_DEVR      = 12'b0010_0000_0000,
    PH_RD_ACK    = 12'b0100_0000_0000,
    PH_RD_NACK   = 12'b1000_0000_0000
  } phase_t;

  // one accepted input item
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   start_address;
    logic [COUNT_W-1:0]  byte_count;
    logic [BYTE_W-1:0]   write_data;
    logic [STATUS_W-1:0] bus_status;
    logic [BYTE_W-1:0]   received_byte;
  } item_t;

  // one result item
  typedef struct packed {
    logic [ACTION_W-1:0] bus_action;
    logic [BYTE_W-1:0]   tx_byte;
    logic [BYTE_W-1:0]   read_data;
    logic                read_valid;
    logic                need_data;
    logic                done_res;
    logic [ERR_W-1:0]    error_code;
    logic                last;
  } res_t;

  // results handed to the output queue in one cycle
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

  // plain bus action, ends the item
  function automatic res_t res_act(input logic [ACTION_W-1:0] act);
    res_t r;
    r = '0;
    r.bus_action = act;
    r.last = 1'b1;
    return r;
  endfunction

  // send one byte
  function automatic res_t res_send(input logic [BYTE_W-1:0] b);
    res_t r;
    r = res_act(ACT_SEND);
    r.tx_byte = b;
    return r;
  endfunction

  // request finished
  function automatic res_t res_done(input logic [ACTION_W-1:0] act,
                                    input logic [ERR_W-1:0] ec);
    res_t r;
    r = res_act(act);
    r.done_res = 1'b1;
    r.error_code = ec;
    return r;
  endfunction

  // number of trailing zero bits of a page size up to 256
  function automatic int trailing_zeros(input int p);
    int   tz;
    logic found;
    tz = 0;
    found = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (!found) begin
        if (p[i]) found = 1'b1;
        else tz++;
      end
    end
    return tz;
  endfunction

  // inverse of an odd number modulo 2^16, newton steps
  function automatic logic [15:0] odd_inverse(input int m);
    logic [15:0] mm;
    logic [15:0] inv;
    mm = m[15:0];
    inv = mm;
    for (int i = 0; i < 4; i++) begin
      inv = 16'(inv * (16'd2 - 16'(mm * inv)));
    end
    return inv;
  endfunction

endpackage

// ----- src/i2cea_ctrl.sv -----
module i2cea_ctrl #(
  parameter int PAGE_BYTES = i2cea_pkg::PAGE_BYTES_DEF,
  parameter int ADDR_BITS  = i2cea_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  i2cea_pkg::item_t                item,
  input  logic                            room,
  input  logic [i2cea_pkg::DEV_W-1:0]     device_address,
  input  logic [i2cea_pkg::POLL_W-1:0]    poll_limit,
  output logic                            fire,
  output i2cea_pkg::push_t                push
);

  // page boundary test: low bits zero and odd part divides, by modular inverse
  localparam int          PAGE_TZ  = i2cea_pkg::trailing_zeros(PAGE_BYTES);
  localparam int          PAGE_ODD = PAGE_BYTES >> PAGE_TZ;
  localparam logic [15:0] PAGE_INV = i2cea_pkg::odd_inverse(PAGE_ODD);
  localparam logic [15:0] PAGE_LIM = 16'(65535 / PAGE_ODD);
  localparam logic [15:0] LOW_MASK = 16'((1 << PAGE_TZ) - 1);

  i2cea_pkg::phase_t                  phase, phase_next;
  logic                               reading, reading_next;
  logic [ADDR_BITS-1:0]               address_counter, address_counter_next;
  logic [i2cea_pkg::COUNT_W-1:0]      bytes_left, bytes_left_next;
  logic [i2cea_pkg::POLL_W-1:0]       poll_count, poll_count_next;

  logic [1:0]                         num;
  i2cea_pkg::res_t                    res0, res1;
  logic [ADDR_BITS-1:0]               addr_inc;
  logic [15:0]                        addr_ext, inc_ext, inc_hi, inc_prod;
  logic                               page_hit;
  logic [i2cea_pkg::COUNT_W-1:0]      bl_dec;
  logic                               st_timeout, st_nack;
  logic [i2cea_pkg::ERR_W-1:0]        nack_err;
  logic [i2cea_pkg::BYTE_W-1:0]       dev_w, dev_r, addr_first;
  i2cea_pkg::phase_t                  addr_first_phase;

  assign fire = item_valid && room;

  // derived values
  assign addr_inc   = address_counter + 1'b1;
  assign addr_ext   = 16'(address_counter);
  assign inc_ext    = 16'(addr_inc);
  assign inc_hi     = inc_ext >> PAGE_TZ;
  assign inc_prod   = 16'(inc_hi * PAGE_INV);
  assign page_hit   = ((inc_ext & LOW_MASK) == 16'd0) && (inc_prod <= PAGE_LIM);
  assign bl_dec     = bytes_left - 1'b1;
  assign st_timeout = item.bus_status[1];
  assign st_nack    = item.bus_status != i2cea_pkg::ST_ACK;
  assign nack_err   = reading ? i2cea_pkg::ERR_READ : i2cea_pkg::ERR_WRITE;
  assign dev_w      = {device_address, 1'b0};
  assign dev_r      = {device_address, 1'b1};

  // narrow memories get the low address byte only
  generate
    if (ADDR_BITS > 8) begin : g_two_byte
      assign addr_first       = addr_ext[15:8];
      assign addr_first_phase = i2cea_pkg::PH_ADDRH;
    end else begin : g_one_byte
      assign addr_first       = addr_ext[7:0];
      assign addr_first_phase = i2cea_pkg::PH_ADDRL;
    end
  endgenerate

  // step logic for one item
  always_comb begin
    phase_next           = phase;
    reading_next         = reading;
    address_counter_next = address_counter;
    bytes_left_next      = bytes_left;
    poll_count_next      = poll_count;
    num                  = 2'd0;
    res0                 = '0;
    res1                 = '0;
    case (phase)
      i2cea_pkg::PH_IDLE: begin
        if (item.kind == i2cea_pkg::KIND_WRITE || item.kind == i2cea_pkg::KIND_READ) begin
          reading_next         = item.kind == i2cea_pkg::KIND_READ;
          address_counter_next = item.start_address[ADDR_BITS-1:0];
          bytes_left_next      = item.byte_count;
          poll_count_next      = '0;
          phase_next           = i2cea_pkg::PH_START;
          res0                 = i2cea_pkg::res_act(i2cea_pkg::ACT_START);
          num                  = 2'd1;
        end
      end
      i2cea_pkg::PH_WAIT_DATA: begin
        if (item.kind == i2cea_pkg::KIND_DATA) begin
          res0       = i2cea_pkg::res_send(item.write_data);
          phase_next = i2cea_pkg::PH_WR_DATA;
          num        = 2'd1;
        end
      end
      default: begin
        if (item.kind == i2cea_pkg::KIND_RESP) begin
          num = 2'd1;
          if (st_timeout) begin
            phase_next = i2cea_pkg::PH_IDLE;
            res0 = i2cea_pkg::res_done(i2cea_pkg::ACT_NONE, i2cea_pkg::ERR_TIMEOUT);
          end else begin
            case (phase)
              i2cea_pkg::PH_START, i2cea_pkg::PH_POLL_RS: begin
                if (st_nack) begin
                  phase_next = i2cea_pkg::PH_IDLE;
                  res0 = i2cea_pkg::res_done(i2cea_pkg::ACT_NONE, i2cea_pkg::ERR_TIMEOUT);
                end else begin
                  phase_next = i2cea_pkg::PH_DEVW;
                  res0 = i2cea_pkg::res_send(dev_w);
                end
              end
              i2cea_pkg::PH_DEVW: begin
                if (st_nack) begin
                  if (poll_count >= poll_limit) begin
                    phase_next = i2cea_pkg::PH_IDLE;
                    res0 = i2cea_pkg::res_done(i2cea_pkg::ACT_STOP, i2cea_pkg::ERR_TIMEOUT);
                  end else begin
                    poll_count_next = poll_count + 1'b1;
                    phase_next = i2cea_pkg::PH_POLL_RS;
                    res0 = i2cea_pkg::res_act(i2cea_pkg::ACT_RESTART);
                  end
                end else begin
                  phase_next = addr_first_phase;
                  res0 = i2cea_pkg::res_send(addr_first);
                end
              end
              i2cea_pkg::PH_ADDRH: begin
                if (st_nack) begin
                  phase_next = i2cea_pkg::PH_IDLE;
                  res0 = i2cea_pkg::res_done(i2cea_pkg::ACT_NONE, nack_err);
                end else begin
                  phase_next = i2cea_pkg::PH_ADDRL;
                  res0 = i2cea_pkg::res_send(addr_ext[7:0]);
                end
              end
              i2cea_pkg::PH_ADDRL: begin
                if (st_nack) begin
                  phase_next = i2cea_pkg::PH_IDLE;
                  res0 = i2cea_pkg::res_done(i2cea_pkg::ACT_NONE, nack_err);
                end else if (reading) begin
                  phase_next = i2cea_pkg::PH_RD_RS;
                  res0 = i2cea_pkg::res_act(i2cea_pkg::ACT_RESTART);
                end else if (bytes_left == '0) begin
                  phase_next = i2cea_pkg::PH_IDLE;
                  res0 = i2cea_pkg::res_done(i2cea_pkg::ACT_STOP, i2cea_pkg::ERR_OK);
                end else begin
                  phase_next = i2cea_pkg::PH_WAIT_DATA;
                  res0 = i2cea_pkg::res_act(i2cea_pkg::ACT_NONE);
                  res0.need_data = 1'b1;
                end
              end
              i2cea_pkg::PH_WR_DATA: begin
                if (st_nack) begin
                  phase_next = i2cea_pkg::PH_IDLE;
                  res0 = i2cea_pkg::res_done(i2cea_pkg::ACT_NONE, i2cea_pkg::ERR_WRITE);
                end else begin
                  bytes_left_next      = bl_dec;
                  address_counter_next = addr_inc;
                  if (page_hit) begin
                    // page boundary: stop, then redo the whole set-up
                    poll_count_next = '0;
                    phase_next = i2cea_pkg::PH_START;
                    res0 = i2cea_pkg::res_act(i2cea_pkg::ACT_STOP);
                    res0.last = 1'b0;
                    res1 = i2cea_pkg::res_act(i2cea_pkg::ACT_START);
                    num = 2'd2;
                  end else if (bl_dec == '0) begin
                    phase_next = i2cea_pkg::PH_IDLE;
                    res0 = i2cea_pkg::res_done(i2cea_pkg::ACT_STOP, i2cea_pkg::ERR_OK);
                  end else begin
                    phase_next = i2cea_pkg::PH_WAIT_DATA;
                    res0 = i2cea_pkg::res_act(i2cea_pkg::ACT_NONE);
                    res0.need_data = 1'b1;
                  end
                end
              end
              i2cea_pkg::PH_RD_RS: begin
                if (st_nack) begin
                  phase_next = i2cea_pkg::PH_IDLE;
                  res0 = i2cea_pkg::res_done(i2cea_pkg::ACT_NONE, i2cea_pkg::ERR_READ);
                end else begin
                  phase_next = i2cea_pkg::PH_DEVR;
                  res0 = i2cea_pkg::res_send(dev_r);
                end
              end
              i2cea_pkg::PH_DEVR: begin
                if (st_nack) begin
                  phase_next = i2cea_pkg::PH_IDLE;
                  res0 = i2cea_pkg::res_done(i2cea_pkg::ACT_NONE, i2cea_pkg::ERR_READ);
                end else if (bytes_left > 16'd1) begin
                  phase_next = i2cea_pkg::PH_RD_ACK;
                  res0 = i2cea_pkg::res_act(i2cea_pkg::ACT_RX_ACK);
                end else begin
                  phase_next = i2cea_pkg::PH_RD_NACK;
                  res0 = i2cea_pkg::res_act(i2cea_pkg::ACT_RX_NACK);
                end
              end
              i2cea_pkg::PH_RD_ACK: begin
                if (st_nack) begin
                  phase_next = i2cea_pkg::PH_IDLE;
                  res0 = i2cea_pkg::res_done(i2cea_pkg::ACT_NONE, i2cea_pkg::ERR_READ);
                end else begin
                  bytes_left_next = bl_dec;
                  if (bl_dec > 16'd1) begin
                    phase_next = i2cea_pkg::PH_RD_ACK;
                    res0 = i2cea_pkg::res_act(i2cea_pkg::ACT_RX_ACK);
                  end else begin
                    phase_next = i2cea_pkg::PH_RD_NACK;
                    res0 = i2cea_pkg::res_act(i2cea_pkg::ACT_RX_NACK);
                  end
                  res0.read_data  = item.received_byte;
                  res0.read_valid = 1'b1;
                end
              end
              i2cea_pkg::PH_RD_NACK: begin
                if (st_nack) begin
                  phase_next = i2cea_pkg::PH_IDLE;
                  res0 = i2cea_pkg::res_done(i2cea_pkg::ACT_NONE, i2cea_pkg::ERR_READ);
                end else begin
                  phase_next = i2cea_pkg::PH_IDLE;
                  res0 = i2cea_pkg::res_done(i2cea_pkg::ACT_STOP, i2cea_pkg::ERR_OK);
                  res0.read_data  = item.received_byte;
                  res0.read_valid = 1'b1;
                end
              end
              default: begin
                phase_next = i2cea_pkg::PH_IDLE;
                num = 2'd0;
              end
            endcase
          end
        end
      end
    endcase
  end

  // results go to the output queue only on a processed item
  always_comb begin
    push.num = fire ? num : 2'd0;
    push.r0  = res0;
    push.r1  = res1;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= i2cea_pkg::PH_IDLE;
      reading         <= 1'b0;
      address_counter <= '0;
      bytes_left      <= '0;
      poll_count      <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      reading         <= reading_next;
      address_counter <= address_counter_next;
      bytes_left      <= bytes_left_next;
      poll_count      <= poll_count_next;
    end
  end

`ifndef SYNTHESIS
  // a finishing result returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && push.num != 2'd0 && push.r0.done_res) |=> (phase == i2cea_pkg::PH_IDLE))
    else $error("done result did not return to idle");

  // two results come only from a page boundary after a data byte
  a_two_page: assert property (@(posedge clk) disable iff (rst)
    (push.num == 2'd2) |-> (phase == i2cea_pkg::PH_WR_DATA && page_hit))
    else $error("two results outside a page boundary");

  // asking for data leaves the sequencer waiting for it
  a_need_wait: assert property (@(posedge clk) disable iff (rst)
    (fire && push.num == 2'd1 && push.r0.need_data) |=>
      (phase == i2cea_pkg::PH_WAIT_DATA))
    else $error("need_data without waiting for data");
`endif

endmodule

// ----- src/i2cea_outq.sv -----
module i2cea_outq (
  input  logic              clk,
  input  logic              rst,
  input  i2cea_pkg::push_t  push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output i2cea_pkg::res_t   out_res
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  i2cea_pkg::res_t     entries [DEPTH];
  logic [PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                pop;
  logic [PTR_W-1:0]    wr_ptr_1;

  // room for the largest burst of one item
  assign room      = count <= CNT_W'(DEPTH - 2);
  assign out_valid = count != '0;
  assign out_res   = entries[rd_ptr];
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_1  = wr_ptr + 1'b1;

  // result storage
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) entries[wr_ptr] <= push.r0;
    if (push.num == 2'd2) entries[wr_ptr_1] <= push.r1;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.num);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count  <= count + CNT_W'(push.num) - CNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  // fill count never passes the depth
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("result queue overflow");

  // results are pushed only when two entries are free
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.num != 2'd0) |-> (count <= CNT_W'(DEPTH - 2)))
    else $error("push into a full result queue");
`endif

endmodule

// ----- src/i2c_eeprom_access_sequencer.sv -----
// Access sequencer for a serial memory with an ADDR_BITS-bit internal address
// (16 by default), placed in front of a byte-level I2C master. Each input item
// (request, write data byte, or bus response) is processed by the sequencer
// logic and produces at most two result items (bus action, read byte, data
// request or completion with error code). An accepted item is held in the
// input register until the sequencer logic handles it, and its results enter a
// four-entry result queue that feeds the output channel. One item is accepted
// every cycle; the input is held only while the result queue has fewer than two
// free entries, which follows the output side's stall. Acknowledge polling, page
// restarts at each PAGE_BYTES address boundary and read sequencing follow the
// bus responses returned by the master.
module i2c_eeprom_access_sequencer #(
  parameter int PAGE_BYTES = i2cea_pkg::PAGE_BYTES_DEF,
  parameter int ADDR_BITS  = i2cea_pkg::ADDR_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [i2cea_pkg::KIND_W-1:0]       kind,
  input  logic [i2cea_pkg::ADDR_W-1:0]       start_address,
  input  logic [i2cea_pkg::COUNT_W-1:0]      byte_count,
  input  logic [i2cea_pkg::BYTE_W-1:0]       write_data,
  input  logic [i2cea_pkg::STATUS_W-1:0]     bus_status,
  input  logic [i2cea_pkg::BYTE_W-1:0]       received_byte,
  // output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [i2cea_pkg::ACTION_W-1:0]     bus_action,
  output logic [i2cea_pkg::BYTE_W-1:0]       tx_byte,
  output logic [i2cea_pkg::BYTE_W-1:0]       read_data,
  output logic                               read_valid,
  output logic                               need_data,
  output logic                               done_res,
  output logic [i2cea_pkg::ERR_W-1:0]        error_code,
  output logic                               last,
  // configuration port
  input  logic                               cfg_we,
  input  logic [i2cea_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [i2cea_pkg::POLL_W-1:0]       cfg_data
);

  logic                              item_valid;
  i2cea_pkg::item_t                  item;
  logic                              fire;
  logic                              room;
  i2cea_pkg::push_t                  push;
  i2cea_pkg::res_t                   out_res;
  logic [i2cea_pkg::DEV_W-1:0]       device_address;
  logic [i2cea_pkg::POLL_W-1:0]      poll_limit;
  logic                              in_take;

  // input register is free when empty or handled this cycle
  assign in_stall = item_valid && !fire;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.kind          <= kind;
      item.start_address <= start_address;
      item.byte_count    <= byte_count;
      item.write_data    <= write_data;
      item.bus_status    <= bus_status;
      item.received_byte <= received_byte;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= i2cea_pkg::DEVICE_ADDRESS_RST;
      poll_limit     <= i2cea_pkg::POLL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cea_pkg::REG_DEVICE_ADDRESS: device_address <= cfg_data[i2cea_pkg::DEV_W-1:0];
        i2cea_pkg::REG_POLL_LIMIT:     poll_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  i2cea_ctrl #(
    .PAGE_BYTES (PAGE_BYTES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item           (item),
    .room           (room),
    .device_address (device_address),
    .poll_limit     (poll_limit),
    .fire           (fire),
    .push           (push)
  );

  // result queue
  i2cea_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign bus_action = out_res.bus_action;
  assign tx_byte    = out_res.tx_byte;
  assign read_data  = out_res.read_data;
  assign read_valid = out_res.read_valid;
  assign need_data  = out_res.need_data;
  assign done_res   = out_res.done_res;
  assign error_code = out_res.error_code;
  assign last       = out_res.last;

endmodule
